/* rtl/sphr_pkg.sv */
package sphr_pkg;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_FIND   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_NOP    = 2'd3;

   localparam int ID_W         = 8;
   localparam int IO_PAYLOAD_W = 32;
   localparam int REQ_TYPE_W   = 2;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;

endpackage

/* rtl/sphr_mem.sv */
module sphr_mem #(
   parameter int DEPTH = sphr_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = 2 * sphr_pkg::ID_W + sphr_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sphr_ring.sv */
module sphr_ring #(
   parameter int DEPTH = sphr_pkg::DEPTH_DEFAULT
) (
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] base,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] offset,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pos
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(DEPTH);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] wrapped;

   // Both operands are below DEPTH, so one conditional subtract wraps the sum.
   always_comb begin
      sum     = {1'b0, base} + {1'b0, offset};
      wrapped = (sum >= DEPTH_V) ? (sum - DEPTH_V) : sum;
      pos     = wrapped[IDX_W-1:0];
   end

endmodule

/* rtl/sphr_seq.sv */
module sphr_seq #(
   parameter int DEPTH         = sphr_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = sphr_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [sphr_pkg::REQ_TYPE_W-1:0]             req_type,
   input  logic [sphr_pkg::ID_W-1:0]                   req_dst_id,
   input  logic [sphr_pkg::ID_W-1:0]                   req_msg_id,
   input  logic [sphr_pkg::IO_PAYLOAD_W-1:0]           req_payload,
   output logic                                        rsp_valid,
   output logic                                        rsp_hit,
   output logic [sphr_pkg::ID_W-1:0]                   rsp_dst_id,
   output logic [sphr_pkg::ID_W-1:0]                   rsp_msg_id,
   output logic [sphr_pkg::IO_PAYLOAD_W-1:0]           rsp_payload,
   output logic [$clog2(DEPTH+1)-1:0]                  rsp_occupancy,
   output logic                                        mem_we,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
   output logic [2*sphr_pkg::ID_W+PAYLOAD_WIDTH-1:0]   mem_wdata,
   output logic                                        mem_re,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
   input  logic [2*sphr_pkg::ID_W+PAYLOAD_WIDTH-1:0]   mem_rdata,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ring_base,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ring_ofs,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ring_pos
);

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = sphr_pkg::ID_W;
   localparam int IO_PW   = sphr_pkg::IO_PAYLOAD_W;
   localparam int ENTRY_W = 2 * ID_W + PAYLOAD_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]         state_ff,    state_in;
   logic [IDX_W-1:0]   head_ff,     head_in;
   logic [CNT_W-1:0]   count_ff,    count_in;
   logic [CNT_W-1:0]   ofs_ff,      ofs_in;
   logic               pend_ff,     pend_in;
   logic [IDX_W-1:0]   rd_addr_ff,  rd_addr_in;
   logic [IDX_W-1:0]   wr_addr_ff,  wr_addr_in;
   logic [ID_W-1:0]    key_ff,      key_in;
   logic               remove_ff,   remove_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff,  rsp_hit_in;
   logic [ID_W-1:0]    rsp_dst_ff,  rsp_dst_in;
   logic [ID_W-1:0]    rsp_msg_ff,  rsp_msg_in;
   logic [IO_PW-1:0]   rsp_pay_ff,  rsp_pay_in;
   logic [CNT_W-1:0]   rsp_occ_ff,  rsp_occ_in;

   logic                       full;
   logic                       key_eq;
   logic                       issue;
   logic [ID_W-1:0]            rd_dst;
   logic [ID_W-1:0]            rd_msg;
   logic [PAYLOAD_WIDTH-1:0]   rd_pay;
   logic [PAYLOAD_WIDTH+IO_PW-1:0] pay_store_ext;
   logic [PAYLOAD_WIDTH+IO_PW-1:0] pay_out_ext;

   always_comb begin
      rd_dst        = mem_rdata[ENTRY_W-1 -: ID_W];
      rd_msg        = mem_rdata[PAYLOAD_WIDTH+ID_W-1 -: ID_W];
      rd_pay        = mem_rdata[PAYLOAD_WIDTH-1:0];
      pay_store_ext = {{PAYLOAD_WIDTH{1'b0}}, req_payload};
      pay_out_ext   = {{IO_PW{1'b0}}, rd_pay};
      full          = (count_ff == DEPTH_C);
      key_eq        = ((rd_dst ^ rd_msg) == key_ff);
      issue         = (ofs_ff < count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ofs_in       = ofs_ff;
      pend_in      = pend_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      key_in       = key_ff;
      remove_in    = remove_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_msg_in   = rsp_msg_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_occ_in   = rsp_occ_ff;

      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = ring_pos;
      ring_base = head_ff;
      ring_ofs  = ofs_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_type)
                  sphr_pkg::REQ_ADD: begin
                     // A full ring overwrites the oldest entry and moves the head on.
                     ring_ofs  = full ? IDX_W'(1) : count_ff[IDX_W-1:0];
                     mem_we    = 1'b1;
                     mem_waddr = full ? head_ff : ring_pos;
                     mem_wdata = {req_dst_id, req_msg_id, pay_store_ext[PAYLOAD_WIDTH-1:0]};
                     if (full) begin
                        head_in = ring_pos;
                     end else begin
                        count_in = count_ff + ONE_C;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = full;
                     rsp_dst_in   = '0;
                     rsp_msg_in   = '0;
                     rsp_pay_in   = '0;
                     rsp_occ_in   = count_in;
                  end
                  sphr_pkg::REQ_FIND, sphr_pkg::REQ_REMOVE: begin
                     key_in    = req_dst_id ^ req_msg_id;
                     remove_in = (req_type == sphr_pkg::REQ_REMOVE);
                     ofs_in    = '0;
                     pend_in   = 1'b0;
                     state_in  = S_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b0;
                     rsp_dst_in   = '0;
                     rsp_msg_in   = '0;
                     rsp_pay_in   = '0;
                     rsp_occ_in   = count_ff;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Reads are issued one a cycle; the compare runs one entry behind.
            if (pend_ff && key_eq) begin
               rsp_hit_in = 1'b1;
               rsp_dst_in = rd_dst;
               rsp_msg_in = rd_msg;
               rsp_pay_in = pay_out_ext[IO_PW-1:0];
               pend_in    = 1'b0;
               if (remove_ff) begin
                  // The next entry to move sits at the offset already counted up.
                  wr_addr_in = rd_addr_ff;
                  state_in   = S_SHIFT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_occ_in   = count_ff;
                  state_in     = S_IDLE;
               end
            end else if (issue) begin
               mem_re     = 1'b1;
               rd_addr_in = ring_pos;
               ofs_in     = ofs_ff + ONE_C;
               pend_in    = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_dst_in   = '0;
               rsp_msg_in   = '0;
               rsp_pay_in   = '0;
               rsp_occ_in   = count_ff;
               pend_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = wr_addr_ff;
               mem_wdata  = mem_rdata;
               wr_addr_in = rd_addr_ff;
            end
            if (issue) begin
               mem_re     = 1'b1;
               rd_addr_in = ring_pos;
               ofs_in     = ofs_ff + ONE_C;
               pend_in    = 1'b1;
            end else begin
               pend_in      = 1'b0;
               count_in     = count_ff - ONE_C;
               rsp_valid_in = 1'b1;
               rsp_occ_in   = count_in;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ofs_ff     <= ofs_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      key_ff     <= key_in;
      remove_ff  <= remove_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_dst_ff <= rsp_dst_in;
      rsp_msg_ff <= rsp_msg_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_dst_id    = rsp_dst_ff;
   assign rsp_msg_id    = rsp_msg_ff;
   assign rsp_payload   = rsp_pay_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count exceeds ring depth");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while a request is still in progress");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("compaction reads and writes the same entry");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid_ff))
      else $error("accepted item neither in progress nor answered");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)
         || count_ff == $past(count_ff) + ONE_C
         || count_ff + ONE_C == $past(count_ff)))
      else $error("entry count moved by more than one");
`endif

endmodule

/* rtl/sent_packet_history_ring.sv */
// Channel   Handshake             Payload
// request   start, busy           req_type, req_dst_id, req_msg_id, req_payload
// response  rsp_valid (strobe)    rsp_hit, rsp_dst_id, rsp_msg_id, rsp_payload,
//                                 rsp_occupancy
//
// An add or an unused code is answered in the cycle after it is taken.
// Find and remove scan the ring through one memory read port and one key
// comparator, one entry a cycle.
// A remove then shifts the later entries down one per cycle.
// Reset is synchronous and clears head and count; the entry memory is not cleared.
// The response strobe lasts one cycle and cannot be stalled.
module sent_packet_history_ring #(
   parameter int DEPTH         = sphr_pkg::DEPTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = sphr_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sphr_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [sphr_pkg::ID_W-1:0]         req_dst_id,
   input  logic [sphr_pkg::ID_W-1:0]         req_msg_id,
   input  logic [sphr_pkg::IO_PAYLOAD_W-1:0] req_payload,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [sphr_pkg::ID_W-1:0]         rsp_dst_id,
   output logic [sphr_pkg::ID_W-1:0]         rsp_msg_id,
   output logic [sphr_pkg::IO_PAYLOAD_W-1:0] rsp_payload,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_occupancy
);

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = 2 * sphr_pkg::ID_W + PAYLOAD_WIDTH;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;
   logic [IDX_W-1:0]   ring_base;
   logic [IDX_W-1:0]   ring_ofs;
   logic [IDX_W-1:0]   ring_pos;

   sphr_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sphr_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .base   (ring_base),
      .offset (ring_ofs),
      .pos    (ring_pos)
   );

   sphr_seq #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_dst_id    (req_dst_id),
      .req_msg_id    (req_msg_id),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_dst_id    (rsp_dst_id),
      .rsp_msg_id    (rsp_msg_id),
      .rsp_payload   (rsp_payload),
      .rsp_occupancy (rsp_occupancy),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_re        (mem_re),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata),
      .ring_base     (ring_base),
      .ring_ofs      (ring_ofs),
      .ring_pos      (ring_pos)
   );

endmodule

/* tb/sent_packet_history_ring_checker.sv */
`timescale 1ns / 1ps

module sent_packet_history_ring_checker #(
   parameter int DEPTH = sphr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [sphr_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [sphr_pkg::ID_W-1:0]         req_dst_id,
   input  logic [sphr_pkg::ID_W-1:0]         req_msg_id,
   input  logic [sphr_pkg::IO_PAYLOAD_W-1:0] req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_hit,
   input  logic [sphr_pkg::ID_W-1:0]         rsp_dst_id,
   input  logic [sphr_pkg::ID_W-1:0]         rsp_msg_id,
   input  logic [sphr_pkg::IO_PAYLOAD_W-1:0] rsp_payload,
   input  logic [$clog2(DEPTH+1)-1:0]        rsp_occupancy,
   output int                                error_total,
   output int                                pending_total,
   output int                                match_total,
   output int                                evict_total
);

   import sphr_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic                    hit;
      logic [ID_W-1:0]         dst_id;
      logic [ID_W-1:0]         msg_id;
      logic [IO_PAYLOAD_W-1:0] payload;
      logic [OCC_W-1:0]        occupancy;
   } history_reply_type;

   // Shadow copy of the ring.
   logic [ID_W-1:0]         ring_dst [DEPTH];
   logic [ID_W-1:0]         ring_msg [DEPTH];
   logic [IO_PAYLOAD_W-1:0] ring_pay [DEPTH];
   int                      ring_head;
   int                      ring_count;

   history_reply_type pending_replies[$];
   history_reply_type want;
   int                errors;
   int                match_count;
   int                evictions;

   assign error_total = errors;
   assign match_total = match_count;
   assign evict_total = evictions;

   initial begin
      errors        = 0;
      match_count   = 0;
      evictions     = 0;
      ring_head     = 0;
      ring_count    = 0;
      pending_total = 0;
   end

   function automatic history_reply_type predict_reply(
      input logic [REQ_TYPE_W-1:0]   kind,
      input logic [ID_W-1:0]         dst,
      input logic [ID_W-1:0]         msg,
      input logic [IO_PAYLOAD_W-1:0] pay
   );
      history_reply_type r;
      int                slot;
      int                at;
      int                i;
      logic [ID_W-1:0]   key;
      r = '0;
      case (kind)
         REQ_ADD: begin
            if (ring_count < DEPTH) begin
               slot = (ring_head + ring_count) % DEPTH;
               ring_count++;
            end else begin
               // A full ring drops its oldest item and the head moves on.
               slot      = ring_head;
               ring_head = (ring_head + 1) % DEPTH;
               r.hit     = 1'b1;
            end
            ring_dst[slot] = dst;
            ring_msg[slot] = msg;
            ring_pay[slot] = pay;
         end
         REQ_FIND, REQ_REMOVE: begin
            key = dst ^ msg;
            at  = ring_count;
            for (i = 0; i < ring_count; i++) begin
               slot = (ring_head + i) % DEPTH;
               if (at == ring_count && (ring_dst[slot] ^ ring_msg[slot]) == key)
                  at = i;
            end
            if (at < ring_count) begin
               slot      = (ring_head + at) % DEPTH;
               r.hit     = 1'b1;
               r.dst_id  = ring_dst[slot];
               r.msg_id  = ring_msg[slot];
               r.payload = ring_pay[slot];
               if (kind == REQ_REMOVE) begin
                  for (i = at; i + 1 < ring_count; i++) begin
                     ring_dst[(ring_head + i) % DEPTH] = ring_dst[(ring_head + i + 1) % DEPTH];
                     ring_msg[(ring_head + i) % DEPTH] = ring_msg[(ring_head + i + 1) % DEPTH];
                     ring_pay[(ring_head + i) % DEPTH] = ring_pay[(ring_head + i + 1) % DEPTH];
                  end
                  ring_count--;
               end
            end
         end
         default: begin
         end
      endcase
      r.occupancy = ring_count[OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ring_head  = 0;
         ring_count = 0;
         pending_replies.delete();
      end else begin
         // A response at this edge always belongs to an item taken earlier.
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no item outstanding: hit %0b dst %02h msg %02h",
                           $realtime, rsp_hit, rsp_dst_id, rsp_msg_id);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_hit !== want.hit || rsp_dst_id !== want.dst_id ||
                   rsp_msg_id !== want.msg_id || rsp_payload !== want.payload ||
                   rsp_occupancy !== want.occupancy) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected hit %0b dst %02h msg %02h payload %08h occ %0d",
                              want.hit, want.dst_id, want.msg_id, want.payload,
                              want.occupancy);
                     $display("   actual   hit %0b dst %02h msg %02h payload %08h occ %0d",
                              rsp_hit, rsp_dst_id, rsp_msg_id, rsp_payload, rsp_occupancy);
                  end
               end
            end
         end
         if (start && !busy) begin
            want = predict_reply(req_type, req_dst_id, req_msg_id, req_payload);
            if (want.hit && req_type == REQ_ADD)
               evictions++;
            else if (want.hit)
               match_count++;
            pending_replies.push_back(want);
         end
      end
      pending_total <= pending_replies.size();
   end

endmodule

/* tb/tb_sent_packet_history_ring.sv */
`timescale 1ns / 1ps

module tb_sent_packet_history_ring;

   import sphr_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int OCC_W = $clog2(DEPTH + 1);

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [ID_W-1:0]         req_dst_id;
   logic [ID_W-1:0]         req_msg_id;
   logic [IO_PAYLOAD_W-1:0] req_payload;
   logic                    rsp_valid;
   logic                    rsp_hit;
   logic [ID_W-1:0]         rsp_dst_id;
   logic [ID_W-1:0]         rsp_msg_id;
   logic [IO_PAYLOAD_W-1:0] rsp_payload;
   logic [OCC_W-1:0]        rsp_occupancy;

   int error_total;
   int pending_total;
   int match_total;
   int evict_total;

   int              burst_left;
   int              kind_count [4];
   logic [ID_W-1:0] recent_keys[$];

   sent_packet_history_ring #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH_DEFAULT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_dst_id    (req_dst_id),
      .req_msg_id    (req_msg_id),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_dst_id    (rsp_dst_id),
      .rsp_msg_id    (rsp_msg_id),
      .rsp_payload   (rsp_payload),
      .rsp_occupancy (rsp_occupancy)
   );

   sent_packet_history_ring_checker #(
      .DEPTH (DEPTH)
   ) history_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_dst_id    (req_dst_id),
      .req_msg_id    (req_msg_id),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_dst_id    (rsp_dst_id),
      .rsp_msg_id    (rsp_msg_id),
      .rsp_payload   (rsp_payload),
      .rsp_occupancy (rsp_occupancy),
      .error_total   (error_total),
      .pending_total (pending_total),
      .match_total   (match_total),
      .evict_total   (evict_total)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Called just after a falling edge. Returns at a falling edge after the item
   // was taken, with start still high when the current burst goes on.
   task automatic send_item(input logic [REQ_TYPE_W-1:0] kind, input logic [ID_W-1:0] dst,
                            input logic [ID_W-1:0] msg, input logic [IO_PAYLOAD_W-1:0] pay);
      start       <= 1'b1;
      req_type    <= kind;
      req_dst_id  <= dst;
      req_msg_id  <= msg;
      req_payload <= pay;
      kind_count[kind]++;
      if (kind == REQ_ADD) begin
         recent_keys.push_back(dst ^ msg);
         if (recent_keys.size() > 24)
            void'(recent_keys.pop_front());
      end
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(40, 80);
         else
            burst_left = $urandom_range(0, 15);
      end
   endtask

   initial begin
      int              n;
      int              mode;
      int              pick;
      logic [ID_W-1:0] dst;
      logic [ID_W-1:0] msg;
      logic [ID_W-1:0] key;

      reset       = 1'b1;
      start       = 1'b0;
      req_type    = REQ_ADD;
      req_dst_id  = '0;
      req_msg_id  = '0;
      req_payload = '0;
      burst_left  = 4;
      mode        = 0;
      for (n = 0; n < 4; n++)
         kind_count[n] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Lookups on an empty ring, then an unused code with every bit set.
      send_item(REQ_FIND, 8'h12, 8'h34, 32'h0);
      send_item(REQ_REMOVE, 8'h12, 8'h34, 32'hFFFF_FFFF);
      send_item(REQ_NOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      // Two items sharing key zero: the oldest one is found first.
      send_item(REQ_ADD, 8'h00, 8'h00, 32'h0000_0000);
      send_item(REQ_ADD, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_item(REQ_FIND, 8'h5A, 8'h5A, 32'h0);
      send_item(REQ_REMOVE, 8'hA5, 8'hA5, 32'h0);
      send_item(REQ_FIND, 8'h00, 8'h00, 32'h0);
      // Fill the ring, then overwrite the oldest item and look for it.
      for (n = 1; n < DEPTH; n++)
         send_item(REQ_ADD, n[ID_W-1:0], 8'h80, $urandom);
      send_item(REQ_ADD, 8'h3C, 8'hC3, $urandom);
      send_item(REQ_FIND, 8'hFF, 8'hFF, 32'h0);

      for (n = 0; n < 1500; n++) begin
         // Phases that favor filling, draining or a mix keep occupancy moving.
         if (n % 64 == 0)
            mode = $urandom_range(0, 2);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_item(REQ_NOP, $urandom, $urandom, $urandom);
         end else if (pick < (mode == 0 ? 65 : (mode == 1 ? 25 : 42))) begin
            if ($urandom_range(0, 9) < 3) begin
               dst = $urandom_range(0, 3);
               msg = $urandom_range(0, 3);
            end else begin
               dst = $urandom;
               msg = $urandom;
            end
            send_item(REQ_ADD, dst, msg, $urandom);
         end else begin
            dst = $urandom;
            if (recent_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
               key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
               msg = dst ^ key;
            end else begin
               msg = $urandom;
            end
            if ($urandom_range(0, 99) < (mode == 1 ? 70 : 50))
               send_item(REQ_REMOVE, dst, msg, $urandom);
            else
               send_item(REQ_FIND, dst, msg, $urandom);
         end
      end
      start <= 1'b0;

      while (pending_total != 0) @(negedge clock);
      repeat (2 * DEPTH + 8) @(negedge clock);

      $display("Sent %0d adds, %0d finds, %0d removes and %0d unused codes.",
               kind_count[REQ_ADD], kind_count[REQ_FIND], kind_count[REQ_REMOVE],
               kind_count[REQ_NOP]);
      $display("Lookups matched %0d times; %0d adds overwrote the oldest item of a full ring.",
               match_total, evict_total);
      if (error_total == 0 && pending_total == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
